[rtl/ntt_bf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntt_bf_pkg
// Shared types and constants for the NTT butterfly.
// ----------------------------------------------------------------------------
package ntt_bf_pkg;

  localparam int FIELD_W    = 62;
  localparam int MU_W       = 64;
  localparam int NARROW_B   = 52;
  localparam int PRIME_CNT  = 3;

  // configuration register indexes
  localparam logic [2:0] REG_MODULUS_0 = 3'd0;
  localparam logic [2:0] REG_MODULUS_1 = 3'd1;
  localparam logic [2:0] REG_MODULUS_2 = 3'd2;
  localparam logic [2:0] REG_MU_0      = 3'd3;
  localparam logic [2:0] REG_MU_1      = 3'd4;
  localparam logic [2:0] REG_MU_2      = 3'd5;
  localparam logic [2:0] REG_CLASS     = 3'd6;

  // per-item side data that travels along the pipeline
  typedef struct packed {
    logic [FIELD_W-1:0] even;
    logic [FIELD_W-1:0] q;
    logic [MU_W-1:0]    mu;
    logic               wide;
  } side_t;

endpackage
`default_nettype wire

[rtl/ntt_bf_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntt_bf_mul
// 64x64 multiplier, two stages: 32x32 partial products, then their sum.
// ----------------------------------------------------------------------------
module ntt_bf_mul import ntt_bf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic      [127:0] p
);

  logic [63:0] p00, p01, p10, p11;

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= a[31:0]  * b[31:0];
      p01 <= a[31:0]  * b[63:32];
      p10 <= a[63:32] * b[31:0];
      p11 <= a[63:32] * b[63:32];
      p   <= {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
    end
  end

endmodule
`default_nettype wire

[rtl/ntt_modular_butterfly_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntt_modular_butterfly_top
// Cooley-Tukey NTT butterfly with Barrett modular multiplication.
// ----------------------------------------------------------------------------
// Takes one item (even, odd, twiddle, prime select) per cycle when not stalled
// and returns (even + odd*tw) mod q and (even - odd*tw) mod q. Fully pipelined:
// one item per clock sustained unless the output stalls. Three
// 64x64 products (odd*tw, V*mu, h*q) each take two stages built from 32x32
// partial products; the rest is one add/compare per stage. The whole pipe
// advances together and holds on an output stall, so in_ready follows
// out_ready when the output register is full. Config writes are taken at
// any time (cfg_ready is tied high) but must only be issued while idle.
// Selector 3 maps to prime 2. Bit i of the class mask picks the wide recipe
// (b = COEFF_WIDTH) for prime i, else the 52-bit recipe.
// ----------------------------------------------------------------------------
module ntt_modular_butterfly_top import ntt_bf_pkg::*; #(
  parameter int COEFF_WIDTH = 62
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // config
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  // input items
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FIELD_W-1:0] even_coeff,
  input  wire logic [FIELD_W-1:0] odd_coeff,
  input  wire logic [FIELD_W-1:0] twiddle,
  input  wire logic [1:0]         prime_select,
  // result items
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [FIELD_W-1:0] sum_out,
  output logic      [FIELD_W-1:0] diff_out
);

  localparam int LAST = 10;  // stage index of the output register

  localparam logic [63:0] DATA_MASK64 = (64'd1 << COEFF_WIDTH) - 64'd1;
  localparam logic [FIELD_W-1:0] DATA_MASK = DATA_MASK64[FIELD_W-1:0];
  localparam logic [63:0] V_MASK = (64'd1 << (COEFF_WIDTH + 1)) - 64'd1;
  localparam logic [64:0] RING_W_FULL = (65'd1 << (COEFF_WIDTH + 2)) - 65'd1;
  localparam logic [63:0] RING_W = RING_W_FULL[63:0];
  localparam logic [63:0] RING_N = (64'd1 << (NARROW_B + 2)) - 64'd1;

  // config registers
  logic [FIELD_W-1:0] modulus [PRIME_CNT];
  logic [MU_W-1:0]    mu_reg  [PRIME_CNT];
  logic [2:0]         class_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PRIME_CNT; i++) begin
        modulus[i] <= FIELD_W'(3);
        mu_reg[i]  <= '0;
      end
      class_mask <= 3'b111;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODULUS_0: modulus[0] <= cfg_data[FIELD_W-1:0];
        REG_MODULUS_1: modulus[1] <= cfg_data[FIELD_W-1:0];
        REG_MODULUS_2: modulus[2] <= cfg_data[FIELD_W-1:0];
        REG_MU_0:      mu_reg[0]  <= cfg_data;
        REG_MU_1:      mu_reg[1]  <= cfg_data;
        REG_MU_2:      mu_reg[2]  <= cfg_data;
        REG_CLASS:     class_mask <= cfg_data[2:0];
        default:       ;
      endcase
    end
  end

  // pipeline control: everything moves together unless the output is stuck
  logic en;
  logic [LAST:0] vld;

  assign en        = !vld[LAST] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  // stage 0: capture operands and look up the selected prime
  logic [1:0] sel;
  assign sel = (prime_select == 2'd3) ? 2'd2 : prime_select;

  side_t side [LAST];
  logic [FIELD_W-1:0] odd0, tw0;

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].even <= even_coeff & DATA_MASK;
      side[0].q    <= modulus[sel] & DATA_MASK;
      side[0].mu   <= mu_reg[sel];
      side[0].wide <= class_mask[sel];
      odd0         <= odd_coeff & DATA_MASK;
      tw0          <= twiddle & DATA_MASK;
      for (int k = 1; k < LAST; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // stages 1-2: U = odd * tw
  logic [127:0] prod_u;
  ntt_bf_mul u_mul_u (
    .clk (clk),
    .en  (en),
    .a   ({2'd0, odd0}),
    .b   ({2'd0, tw0}),
    .p   (prod_u)
  );

  // stages 3-4: P = V * mu, V = U >> (b-1) kept to COEFF_WIDTH+1 bits
  logic [127:0] v_shift;
  logic [63:0]  v_val;
  assign v_shift = side[2].wide ? (prod_u >> (COEFF_WIDTH - 1)) : (prod_u >> (NARROW_B - 1));
  assign v_val   = v_shift[63:0] & V_MASK;

  logic [127:0] prod_p;
  ntt_bf_mul u_mul_p (
    .clk (clk),
    .en  (en),
    .a   (v_val),
    .b   (side[2].mu),
    .p   (prod_p)
  );

  // low word of U follows to the subtract stage
  logic [63:0] ulo [3:6];
  always_ff @(posedge clk) begin
    if (en) begin
      ulo[3] <= prod_u[63:0];
      for (int k = 4; k <= 6; k++) begin
        ulo[k] <= ulo[k-1];
      end
    end
  end

  // stages 5-6: X = h * q, h = P >> (b+1)
  logic [127:0] h_shift;
  logic [127:0] prod_x;
  assign h_shift = side[4].wide ? (prod_p >> (COEFF_WIDTH + 1)) : (prod_p >> (NARROW_B + 1));

  ntt_bf_mul u_mul_x (
    .clk (clk),
    .en  (en),
    .a   (h_shift[63:0]),
    .b   ({2'd0, side[4].q}),
    .p   (prod_x)
  );

  // stage 7: r = (U - h*q) mod 2^(b+2)
  logic [63:0] ring;
  logic [63:0] r7;
  assign ring = side[6].wide ? RING_W : RING_N;

  // stage 8: final Barrett correction
  logic [63:0] q2_7, q_7;
  logic [FIELD_W-1:0] t8;
  logic [63:0] r_corr;
  assign q_7    = {2'd0, side[7].q};
  assign q2_7   = {1'b0, side[7].q, 1'b0};
  assign r_corr = (r7 >= q2_7) ? (r7 - q2_7) : ((r7 >= q_7) ? (r7 - q_7) : r7);

  // stage 9: raw sum and difference with their correction flags
  logic [FIELD_W:0]   s_sum;
  logic [FIELD_W:0]   s9;
  logic [FIELD_W-1:0] d9;
  logic               s_ge9, d_neg9;
  assign s_sum = {1'b0, side[8].even} + {1'b0, t8};

  always_ff @(posedge clk) begin
    if (en) begin
      r7     <= ((ulo[6] & ring) - (prod_x[63:0] & ring)) & ring;
      t8     <= r_corr[FIELD_W-1:0] & DATA_MASK;
      s9     <= s_sum;
      s_ge9  <= s_sum >= {1'b0, side[8].q};
      d9     <= side[8].even - t8;
      d_neg9 <= side[8].even < t8;
      // stage 10: output register
      sum_out  <= (s_ge9 ? (s9[FIELD_W-1:0] - side[9].q) : s9[FIELD_W-1:0]) & DATA_MASK;
      diff_out <= (d_neg9 ? (d9 + side[9].q) : d9) & DATA_MASK;
    end
  end

endmodule
`default_nettype wire
